>>> rtl/fpma_pkg.sv
`timescale 1ns / 1ps
package fpma_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SIZE_BITS = 16;

	localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_BITS = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_ALLOC   = 2'd1;
	localparam logic [1:0] CMD_RESTORE = 2'd2;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_BLOCKS = 1'b1;

	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [IDX_BITS-1:0]  idx_t;

	// search record handed from cell to cell
	typedef struct packed {
		logic  valid;
		logic  found;
		idx_t  idx;
		size_t size;
	} rec_t;

	// table writes broadcast to every cell
	typedef struct packed {
		logic  load;
		logic  restore;
		logic  upd;
		idx_t  idx;
		size_t data;
	} cell_wr_t;

	// search settings; the user must keep them stable while a scan runs, the block does not enforce it
	typedef struct packed {
		logic [1:0]          policy;
		size_t               need;
		logic [CNT_BITS-1:0] active;
	} scan_ctl_t;

	function automatic size_t to_size(input logic [15:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[SIZE_BITS-1:0];
	endfunction

	function automatic logic [15:0] from_size(input size_t v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

endpackage

>>> rtl/fpma_cell.sv
`timescale 1ns / 1ps
module fpma_cell
	import fpma_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  idx_t      idx,
	input  cell_wr_t  wr,
	input  scan_ctl_t ctl,
	input  rec_t      rec_in,
	output rec_t      rec_out
);

	size_t hole_q;
	size_t orig_q;
	logic  valid_q;
	logic  found_q;
	idx_t  idx_q;
	size_t size_q;
	rec_t  rec_d;
	logic  part;
	logic  fits;
	logic  take;

	assign part = 32'(idx) < 32'(ctl.active);
	assign fits = hole_q >= ctl.need;

	always_comb begin
		case (ctl.policy)
			POL_BEST:  take = fits && (!rec_in.found || hole_q < rec_in.size);
			// largest hole wins, the fit check comes at the end of the row
			POL_WORST: take = !rec_in.found || hole_q > rec_in.size;
			default:   take = fits && !rec_in.found;
		endcase
	end

	always_comb begin
		rec_d = rec_in;
		if (part && take) begin
			rec_d.found = 1'b1;
			rec_d.idx   = idx;
			rec_d.size  = hole_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		found_q <= rec_d.found;
		idx_q   <= rec_d.idx;
		size_q  <= rec_d.size;
		if (wr.load && wr.idx == idx) begin
			orig_q <= wr.data;
			hole_q <= wr.data;
		end else if (wr.restore) begin
			hole_q <= orig_q;
		end else if (wr.upd && wr.idx == idx) begin
			hole_q <= wr.data;
		end
	end

	assign rec_out = '{valid: valid_q, found: found_q, idx: idx_q, size: size_q};

endmodule

>>> rtl/fit_policy_memory_allocator.sv
`timescale 1ns / 1ps
// channel  valid      stall      payload
// in       in_valid   in_stall   command, block_slot, request_size
// out      out_valid  out_stall  granted, chosen_slot, size_before, hole_left
// cfg      cfg_we     -          cfg_index, cfg_data
//
// load and restore write the table when accepted; an allocate lasts while
// the search record walks the row of cells, one cell a cycle.
// reset clears control and configuration; table contents are undefined
// until loaded. in_stall is high while an allocate is in flight; a finished
// result waits in the output register and does not block loads or restores.
module fit_policy_memory_allocator
	import fpma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  block_slot,
	input  logic [15:0] request_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic [3:0]  chosen_slot,
	output logic [15:0] size_before,
	output logic [15:0] hole_left
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] policy_q;
	logic [4:0] blocks_q;
	logic       start_q;
	size_t      need_q;
	logic       res_ok_q;
	idx_t       res_idx_q;
	size_t      res_before_q;
	size_t      res_left_q;
	logic       out_valid_q;
	logic       out_ok_q;
	logic [3:0] out_slot_q;
	logic [15:0] out_before_q;
	logic [15:0] out_left_q;

	logic       accept;
	logic       out_free;
	logic       slot_ok;
	logic       res_ok;
	cell_wr_t   wr;
	scan_ctl_t  ctl;
	rec_t       rec_head;
	rec_t       recs [NUM_SLOTS];
	rec_t       rec_tail;
	logic [NUM_SLOTS-1:0] tok;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign slot_ok  = 32'(block_slot) < NUM_SLOTS;

	assign ctl.policy = policy_q;
	assign ctl.need   = need_q;
	assign ctl.active = (32'(blocks_q) > NUM_SLOTS) ? CNT_BITS'(NUM_SLOTS)
		: CNT_BITS'(blocks_q);

	always_comb begin
		wr.load    = accept && command == CMD_LOAD && slot_ok;
		wr.restore = accept && command == CMD_RESTORE;
		wr.upd     = (state_q == ST_DONE) && out_free && res_ok_q;
		if (wr.upd) begin
			wr.idx  = res_idx_q;
			wr.data = res_left_q;
		end else begin
			wr.idx  = IDX_BITS'(block_slot);
			wr.data = to_size(request_size);
		end
	end

	always_comb begin
		rec_head.valid = start_q;
		rec_head.found = 1'b0;
		rec_head.idx   = '0;
		rec_head.size  = '0;
	end

	genvar g;
	generate
		for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
			fpma_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IDX_BITS'(g)),
				.wr      (wr),
				.ctl     (ctl),
				.rec_in  ((g == 0) ? rec_head : recs[(g == 0) ? 0 : g - 1]),
				.rec_out (recs[g])
			);
			assign tok[g] = recs[g].valid;
		end
	endgenerate

	assign rec_tail = recs[NUM_SLOTS-1];
	// worst fit only learns at the end whether the largest hole is enough
	assign res_ok = rec_tail.found
		&& (policy_q != POL_WORST || rec_tail.size >= need_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= POL_FIRST;
			blocks_q    <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POLICY: policy_q <= cfg_data[1:0];
					REG_BLOCKS: blocks_q <= cfg_data;
					default:    ;
				endcase
			end
			start_q <= accept && command == CMD_ALLOC;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_ALLOC) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rec_tail.valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_ALLOC) begin
			need_q <= to_size(request_size);
		end
		if (state_q == ST_SCAN && rec_tail.valid) begin
			res_ok_q     <= res_ok;
			res_idx_q    <= res_ok ? rec_tail.idx : '0;
			res_before_q <= res_ok ? rec_tail.size : '0;
			res_left_q   <= res_ok ? rec_tail.size - need_q : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_ok_q     <= res_ok_q;
			out_slot_q   <= 4'(32'(res_idx_q));
			out_before_q <= from_size(res_before_q);
			out_left_q   <= from_size(res_left_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = out_ok_q;
	assign chosen_slot = out_slot_q;
	assign size_before = out_before_q;
	assign hole_left   = out_left_q;

`ifndef NO_ASSERTIONS
	// only one search record walks the row at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one search record in the row");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rec_tail.valid |-> state_q == ST_SCAN)
		else $error("search record left the row outside a scan");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> chosen_slot == 4'd0 && size_before == 16'd0
			&& hole_left == 16'd0)
		else $error("failed allocation carries non-zero fields");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> hole_left <= size_before)
		else $error("hole grew on allocation");
`endif

endmodule
